// ===== hdl/four_lane_green_scheduler_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the four lane green scheduler
// Clocked concurrent checks with reset gating; each use makes one labeled
// assertion that reports through $error.
// ----------------------------------------------------------------------------
`ifndef FOUR_LANE_GREEN_SCHEDULER_ASSERT_SVH
`define FOUR_LANE_GREEN_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FLS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/fls_pkg.sv =====
// ----------------------------------------------------------------------------
// fls_pkg
// Types, codes and constants shared by the four lane green scheduler.
// ----------------------------------------------------------------------------
package fls_pkg;

    localparam int NUM_LANES  = 4;
    localparam int LANE_W     = 2;
    localparam int COUNT_W    = 10;
    localparam int WAIT_W     = 16;
    localparam int CYCLE_W    = 16;
    localparam int GREEN_W    = 8;
    localparam int SCORE_W    = 7;
    localparam int TOTAL_W    = 12;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_RUN  = 1'b1;

    // Register indexes (byte address = 4 * index)
    localparam logic [CFG_IDX_W-1:0] REG_EMERGENCY_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THRESHOLD      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MID_THRESHOLD       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LONG          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_MEDIUM        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_SHORT         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DISCHARGE_AMOUNT    = 3'd6;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_EMERGENCY_THRESHOLD = 10'd40;
    localparam logic [COUNT_W-1:0] RST_HIGH_THRESHOLD      = 10'd40;
    localparam logic [COUNT_W-1:0] RST_MID_THRESHOLD       = 10'd20;
    localparam logic [GREEN_W-1:0] RST_GREEN_LONG          = 8'd60;
    localparam logic [GREEN_W-1:0] RST_GREEN_MEDIUM        = 8'd45;
    localparam logic [GREEN_W-1:0] RST_GREEN_SHORT         = 8'd30;
    localparam logic [COUNT_W-1:0] RST_DISCHARGE_AMOUNT    = 10'd20;

    localparam logic [CYCLE_W-1:0] CYCLE_RESET = 16'd1;
    localparam logic [WAIT_W-1:0]  WAIT_MAX    = 16'hFFFF;

    // Score: 100 - total / 10, zero once total reaches 1000
    localparam logic [SCORE_W-1:0] SCORE_MAX        = 7'd100;
    localparam logic [TOTAL_W-1:0] SCORE_ZERO_TOTAL = 12'd1000;
    // floor(x * 6554 / 2^16) == floor(x / 10) for all x below 1000
    localparam int                 RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_TEN   = 13'd6554;
    localparam int                 RECIP_SHIFT = 16;
    localparam int                 PROD_W      = COUNT_W + RECIP_W;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [WAIT_W-1:0]  wait_t;
    typedef logic [CYCLE_W-1:0] cycle_t;
    typedef count_t [NUM_LANES-1:0] count_vec_t;
    typedef wait_t  [NUM_LANES-1:0] wait_vec_t;

    typedef struct packed {
        logic [COUNT_W-1:0] emergency_threshold;
        logic [COUNT_W-1:0] high_threshold;
        logic [COUNT_W-1:0] mid_threshold;
        logic [GREEN_W-1:0] green_long;
        logic [GREEN_W-1:0] green_medium;
        logic [GREEN_W-1:0] green_short;
        logic [COUNT_W-1:0] discharge_amount;
    } cfg_t;

    typedef struct packed {
        logic               op;
        logic [COUNT_W-1:0] lane0_count;
        logic [COUNT_W-1:0] lane1_count;
        logic [COUNT_W-1:0] lane2_count;
        logic [COUNT_W-1:0] lane3_count;
    } in_item_t;

    typedef struct packed {
        logic [LANE_W-1:0]  granted_lane;
        logic [GREEN_W-1:0] green_seconds;
        logic               is_emergency;
        logic [COUNT_W-1:0] served_count;
        logic [WAIT_W-1:0]  served_wait;
        logic [SCORE_W-1:0] score;
        logic               all_empty;
        logic [CYCLE_W-1:0] cycle_index;
    } out_item_t;

    typedef struct packed {
        count_vec_t counts;
        wait_vec_t  waits;
        cycle_t     cycle;
    } lane_state_t;

endpackage

// ===== hdl/four_lane_green_scheduler.sv =====
// ----------------------------------------------------------------------------
// four_lane_green_scheduler
// Grants green phases to four lanes from their queued counts and waits.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_data  (fls_pkg::in_item_t)
//   out      output     out_valid / out_stall  out_data (fls_pkg::out_item_t)
//   cfg      input      APB psel/penable       paddr, pwdata, prdata
//
// One item per cycle, sustained, unless a stalled output holds a run item. A
// run item leaves the input register and lands in the result register after
// one pass through the scheduling logic, which then raises out_valid; a load
// item passes from the input register into the lane counts and gives no result.
// Reset clears counts and waits, sets the cycle counter to one and loads
// the register defaults. A stalled output holds back run items only; load
// items keep flowing past a full result register.
// ----------------------------------------------------------------------------
`include "four_lane_green_scheduler_assert.svh"

module four_lane_green_scheduler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  fls_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output fls_pkg::out_item_t                out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fls_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fls_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fls_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    fls_pkg::cfg_t        cfg;
    fls_pkg::lane_state_t state;
    fls_pkg::lane_state_t run_next;
    fls_pkg::out_item_t   result;
    fls_pkg::count_vec_t  load_counts;

    logic                 in_vld_reg;
    logic                 in_vld_next;
    fls_pkg::in_item_t    in_data_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    fls_pkg::out_item_t   out_data_reg;

    logic                 in_xfer;
    logic                 advance;
    logic                 load_en;
    logic                 run_en;

    fls_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fls_sched_calc u_calc (
        .cfg    (cfg),
        .cur    (state),
        .result (result),
        .nxt    (run_next)
    );

    fls_lane_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_en     (load_en),
        .load_counts (load_counts),
        .run_en      (run_en),
        .run_next    (run_next),
        .state       (state)
    );

    always_comb
    begin
        load_counts[0] = in_data_reg.lane0_count;
        load_counts[1] = in_data_reg.lane1_count;
        load_counts[2] = in_data_reg.lane2_count;
        load_counts[3] = in_data_reg.lane3_count;
    end

    // A run item advances only when the result register is free or draining
    assign advance  = in_vld_reg &&
                      ((in_data_reg.op == fls_pkg::OP_LOAD) || !out_vld_reg || !out_stall);
    assign load_en  = advance && (in_data_reg.op == fls_pkg::OP_LOAD);
    assign run_en   = advance && (in_data_reg.op == fls_pkg::OP_RUN);
    assign in_stall = in_vld_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        if (in_xfer)
            in_vld_next = 1'b1;
        else if (advance)
            in_vld_next = 1'b0;
        else
            in_vld_next = in_vld_reg;
    end

    always_comb
    begin
        if (run_en)
            out_vld_next = 1'b1;
        else if (out_vld_reg && !out_stall)
            out_vld_next = 1'b0;
        else
            out_vld_next = out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            in_data_reg <= in_data;
        if (run_en)
            out_data_reg <= result;
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

    `FLS_ASSERT_SAME(a_no_overwrite, clk, rst_n, out_vld_reg && out_stall, !run_en, "result overwritten while stalled")
    `FLS_ASSERT_NEXT(a_run_gives_result, clk, rst_n, run_en, out_vld_reg, "run transfer gave no result")
    `FLS_ASSERT_SAME(a_stall_needs_item, clk, rst_n, in_stall, in_vld_reg, "input stalled with empty input register")
    `FLS_ASSERT_NEXT(a_cycle_advance, clk, rst_n, run_en, state.cycle == fls_pkg::CYCLE_W'($past(state.cycle) + 1'b1), "cycle counter did not advance on run")

endmodule

// ===== hdl/fls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// fls_cfg_regs
// APB register file holding the scheduler thresholds, green times and discharge amount.
// ----------------------------------------------------------------------------
module fls_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fls_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [fls_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [fls_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready,
    output fls_pkg::cfg_t                     cfg
);

    fls_pkg::cfg_t                    cfg_reg;
    fls_pkg::cfg_t                    cfg_next;
    logic                             wr_en;
    logic [fls_pkg::CFG_IDX_W-1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[fls_pkg::CFG_ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                fls_pkg::REG_EMERGENCY_THRESHOLD:
                    cfg_next.emergency_threshold = pwdata[fls_pkg::COUNT_W-1:0];
                fls_pkg::REG_HIGH_THRESHOLD:
                    cfg_next.high_threshold = pwdata[fls_pkg::COUNT_W-1:0];
                fls_pkg::REG_MID_THRESHOLD:
                    cfg_next.mid_threshold = pwdata[fls_pkg::COUNT_W-1:0];
                fls_pkg::REG_GREEN_LONG:
                    cfg_next.green_long = pwdata[fls_pkg::GREEN_W-1:0];
                fls_pkg::REG_GREEN_MEDIUM:
                    cfg_next.green_medium = pwdata[fls_pkg::GREEN_W-1:0];
                fls_pkg::REG_GREEN_SHORT:
                    cfg_next.green_short = pwdata[fls_pkg::GREEN_W-1:0];
                fls_pkg::REG_DISCHARGE_AMOUNT:
                    cfg_next.discharge_amount = pwdata[fls_pkg::COUNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.emergency_threshold <= fls_pkg::RST_EMERGENCY_THRESHOLD;
            cfg_reg.high_threshold      <= fls_pkg::RST_HIGH_THRESHOLD;
            cfg_reg.mid_threshold       <= fls_pkg::RST_MID_THRESHOLD;
            cfg_reg.green_long          <= fls_pkg::RST_GREEN_LONG;
            cfg_reg.green_medium        <= fls_pkg::RST_GREEN_MEDIUM;
            cfg_reg.green_short         <= fls_pkg::RST_GREEN_SHORT;
            cfg_reg.discharge_amount    <= fls_pkg::RST_DISCHARGE_AMOUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            fls_pkg::REG_EMERGENCY_THRESHOLD:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.emergency_threshold);
            fls_pkg::REG_HIGH_THRESHOLD:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.high_threshold);
            fls_pkg::REG_MID_THRESHOLD:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.mid_threshold);
            fls_pkg::REG_GREEN_LONG:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.green_long);
            fls_pkg::REG_GREEN_MEDIUM:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.green_medium);
            fls_pkg::REG_GREEN_SHORT:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.green_short);
            fls_pkg::REG_DISCHARGE_AMOUNT:
                prdata = fls_pkg::CFG_DATA_W'(cfg_reg.discharge_amount);
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== hdl/fls_sched_calc.sv =====
// ----------------------------------------------------------------------------
// fls_sched_calc
// Single-pass scheduling logic: lane pick, green grading, wait aging,
// discharge and score for one run item.
// ----------------------------------------------------------------------------
module fls_sched_calc (
    input  fls_pkg::cfg_t        cfg,
    input  fls_pkg::lane_state_t cur,
    output fls_pkg::out_item_t   result,
    output fls_pkg::lane_state_t nxt
);

    logic [fls_pkg::NUM_LANES-1:0] emerg_hit;
    logic                          emerg;
    logic [fls_pkg::LANE_W-1:0]    emerg_lane;
    logic [fls_pkg::LANE_W-1:0]    max_lane;
    logic [fls_pkg::LANE_W-1:0]    lane;
    fls_pkg::count_t               served_cnt;
    fls_pkg::count_t               left_cnt;
    fls_pkg::wait_t                served_wait;
    logic [fls_pkg::GREEN_W-1:0]   green;
    logic [fls_pkg::TOTAL_W-1:0]   total;
    logic [fls_pkg::PROD_W-1:0]    prod;
    logic [fls_pkg::SCORE_W-1:0]   quot;
    logic [fls_pkg::SCORE_W-1:0]   score;

    always_comb
    begin
        for (int i = 0; i < fls_pkg::NUM_LANES; i++)
        begin
            emerg_hit[i] = cur.counts[i] >= cfg.emergency_threshold;
        end
    end

    assign emerg = |emerg_hit;

    // Lowest-index emergency lane wins
    always_comb
    begin
        if (emerg_hit[0])
            emerg_lane = 2'd0;
        else if (emerg_hit[1])
            emerg_lane = 2'd1;
        else if (emerg_hit[2])
            emerg_lane = 2'd2;
        else
            emerg_lane = 2'd3;
    end

    // Strictly larger count replaces, so ties keep the lower index
    always_comb
    begin
        max_lane = '0;
        for (int i = 1; i < fls_pkg::NUM_LANES; i++)
        begin
            if (cur.counts[i] > cur.counts[max_lane])
                max_lane = fls_pkg::LANE_W'(i);
        end
    end

    assign lane        = emerg ? emerg_lane : max_lane;
    assign served_cnt  = cur.counts[lane];
    // An empty lane has its wait cleared before it is reported
    assign served_wait = (served_cnt == '0) ? '0 : cur.waits[lane];
    assign left_cnt    = (served_cnt > cfg.discharge_amount) ?
                         served_cnt - cfg.discharge_amount : '0;

    always_comb
    begin
        if (served_cnt > cfg.high_threshold)
            green = cfg.green_long;
        else if (served_cnt > cfg.mid_threshold)
            green = cfg.green_medium;
        else
            green = cfg.green_short;
    end

    always_comb
    begin
        for (int i = 0; i < fls_pkg::NUM_LANES; i++)
        begin
            if (fls_pkg::LANE_W'(i) == lane)
            begin
                nxt.counts[i] = left_cnt;
                nxt.waits[i]  = '0;
            end
            else
            begin
                nxt.counts[i] = cur.counts[i];
                if (cur.counts[i] == '0)
                    nxt.waits[i] = '0;
                else if (cur.waits[i] != fls_pkg::WAIT_MAX)
                    nxt.waits[i] = cur.waits[i] + 1'b1;
                else
                    nxt.waits[i] = cur.waits[i];
            end
        end
        nxt.cycle = cur.cycle + 1'b1;
    end

    assign total = fls_pkg::TOTAL_W'(nxt.counts[0]) + fls_pkg::TOTAL_W'(nxt.counts[1])
                 + fls_pkg::TOTAL_W'(nxt.counts[2]) + fls_pkg::TOTAL_W'(nxt.counts[3]);

    // Divide by ten through a reciprocal; valid for totals below 1000
    assign prod = fls_pkg::PROD_W'(total[fls_pkg::COUNT_W-1:0])
                * fls_pkg::PROD_W'(fls_pkg::RECIP_TEN);
    assign quot = prod[fls_pkg::RECIP_SHIFT +: fls_pkg::SCORE_W];

    assign score = (total >= fls_pkg::SCORE_ZERO_TOTAL) ? '0 : fls_pkg::SCORE_MAX - quot;

    always_comb
    begin
        result.granted_lane  = lane;
        result.green_seconds = green;
        result.is_emergency  = emerg;
        result.served_count  = served_cnt;
        result.served_wait   = served_wait;
        result.score         = score;
        result.all_empty     = (total == '0);
        result.cycle_index   = cur.cycle;
    end

endmodule

// ===== hdl/fls_lane_state.sv =====
// ----------------------------------------------------------------------------
// fls_lane_state
// Lane counts, lane waits and the run cycle counter; written by load and
// run transfers.
// ----------------------------------------------------------------------------
module fls_lane_state (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load_en,
    input  fls_pkg::count_vec_t  load_counts,
    input  logic                 run_en,
    input  fls_pkg::lane_state_t run_next,
    output fls_pkg::lane_state_t state
);

    fls_pkg::lane_state_t state_reg;
    fls_pkg::lane_state_t state_next;

    assign state = state_reg;

    always_comb
    begin
        state_next = state_reg;
        if (run_en)
            state_next = run_next;
        else if (load_en)
            state_next.counts = load_counts;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.counts <= '0;
            state_reg.waits  <= '0;
            state_reg.cycle  <= fls_pkg::CYCLE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
